>>> design/assert_macros.svh
// Assertion macros shared by the heightmap terrain classifier modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HMTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define HMTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/hmtc_pkg.sv
// Types and constants shared by the heightmap terrain classifier modules.
`default_nettype none

package hmtc_pkg;

  // One stored cell of the window and line buffers
  typedef struct packed {
    logic        masked;
    logic        inmap;
    logic        uninit;
    logic [15:0] sample;
  } entry_t;

  // Settings the back end reads while it works
  typedef struct packed {
    logic [1:0]  classify_mode;
    logic [15:0] min_wall_height_mm;
    logic [15:0] flat_height_mm;
  } cfg_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SCAN,
    ST_DECIDE
  } back_state_e;

  // Result classes
  typedef enum logic [1:0] {
    CLS_UNINIT,
    CLS_FLAT,
    CLS_OBSTACLE,
    CLS_WALL
  } cell_class_e;

  // Classification modes
  localparam logic [1:0] MODE_FULL      = 2'd0;
  localparam logic [1:0] MODE_ALL_FLAT  = 2'd1;
  localparam logic [1:0] MODE_MASK_ONLY = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_CLASSIFY_MODE = 2'd0;
  localparam logic [1:0] REG_MIN_WALL      = 2'd1;
  localparam logic [1:0] REG_FLAT          = 2'd2;
  localparam logic [1:0] REG_ROW_WIDTH     = 2'd3;

  // Register reset values
  localparam logic [1:0]  RST_CLASSIFY_MODE = MODE_FULL;
  localparam logic [15:0] RST_MIN_WALL      = 16'd200;
  localparam logic [15:0] RST_FLAT          = 16'd30;
  localparam logic [10:0] RST_ROW_WIDTH     = 11'd1024;

  // Variance above which a zero-height cell counts as not initialised
  localparam logic [31:0] UNINIT_VARIANCE = 32'd250000;

  // Window edge length and the number of line buffers behind it
  localparam int WinSize = 5;
  localparam int NumLines = 4;

endpackage

`default_nettype wire

>>> design/hmtc_front.sv
// Front end: turn input words into stored cells and queue them for the back end.
`default_nettype none
`include "assert_macros.svh"

module hmtc_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire logic            mode_i,
  input  wire logic [15:0]     height_mm_i,
  input  wire logic [15:0]     sample_height_mm_i,
  input  wire logic [31:0]     variance_i,
  input  wire logic            masked_i,
  output logic                 q_valid_o,
  output hmtc_pkg::entry_t     q_entry_o,
  input  wire logic            q_pop_i
);

  hmtc_pkg::entry_t slot_q [2];
  hmtc_pkg::entry_t entry;
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push_ok;

  // Build the cell; a drain word stores as an empty, out-of-map cell
  always_comb begin
    entry = '0;
    if (!mode_i) begin
      entry.sample = sample_height_mm_i;
      entry.inmap  = 1'b1;
      entry.uninit = (variance_i > hmtc_pkg::UNINIT_VARIANCE) && (height_mm_i == 16'd0);
      entry.masked = masked_i;
    end
  end

  assign full_o    = (cnt_q == 2'd2);
  assign push_ok   = push_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_entry_o = slot_q[rp_q];

  // Hold queued cells
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wp_q] <= entry;
    end
  end

  // Advance the queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_ok) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      if (push_ok && !q_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push_ok && q_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  `HMTC_ASSERT_ALWAYS(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")
  `HMTC_ASSERT(a_pop_nonempty, q_pop_i |-> (cnt_q != 2'd0), "pop from empty queue")
  `HMTC_ASSERT(a_push_grows, (push_ok && !q_pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1),
               "queue did not grow on push")

endmodule

`default_nettype wire

>>> design/hmtc_back.sv
// Back end: line buffers, 5x5 window, window scan and the result register.
`default_nettype none
`include "assert_macros.svh"

module hmtc_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         restart_i,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] width_i,
  input  wire hmtc_pkg::cfg_t               cfg_i,
  input  wire logic                         q_valid_i,
  input  wire hmtc_pkg::entry_t             q_entry_i,
  output logic                              q_pop_o,
  output logic                              empty_o,
  input  wire logic                         pop_i,
  output logic [1:0]                        cell_class_o,
  output logic [9:0]                        cell_column_o,
  output logic [15:0]                       cell_row_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(4 * MAX_WIDTH + 3);
  localparam int WS = hmtc_pkg::WinSize;
  localparam int NL = hmtc_pkg::NumLines;

  hmtc_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]    cc_q;
  logic [15:0]      row_q;
  logic [SW-1:0]    seen_q;
  hmtc_pkg::entry_t ent_q;
  hmtc_pkg::entry_t rdata_q [NL];
  hmtc_pkg::entry_t head [WS];
  hmtc_pkg::entry_t win_q [WS][WS];
  logic [SW-1:0]    wx [WS];
  logic             emit;
  logic [CW-1:0]    ccen_q, ccen_d;
  logic [15:0]      crow_q, crow_d;
  logic [2:0]       sr_q;
  logic [15:0]      maxd_q, scan_max;
  logic [19:0]      sum_q, scan_sum;
  logic [3:0]       cnt_q, scan_cnt;
  logic [WS-1:0]    colok;
  logic             mem_rd, mem_wr, do_shift, do_scan, load;
  logic [1:0]       cls;
  logic             out_valid_q;
  logic [1:0]       cls_q;
  logic [9:0]       col_q;
  logic [15:0]      orow_q;
  logic [31:0]      colx;

  // Row start ages: k rows back is k*W items back
  always_comb begin
    wx[0] = '0;
    for (int k = 1; k < WS; k++) begin
      wx[k] = wx[k-1] + SW'(width_i);
    end
  end

  // New heads of the window rows; mask entries older than the stream
  always_comb begin
    head[0] = ent_q;
    for (int j = 1; j < WS; j++) begin
      head[j] = rdata_q[j-1];
      head[j].inmap = rdata_q[j-1].inmap && (seen_q >= wx[j]);
    end
  end

  assign emit = (seen_q >= wx[2] + SW'(2));

  // Line buffers: read the slot W items old, then overwrite it
  for (genvar j = 0; j < NL; j++) begin : g_line
    hmtc_pkg::entry_t mem_q [MAX_WIDTH];
    always_ff @(posedge clk_i) begin
      if (mem_rd) rdata_q[j] <= mem_q[cc_q];
      if (mem_wr) mem_q[cc_q] <= head[j];
    end
  end

  // Centre position: two rows back and two columns back, wrapping to the previous row
  always_comb begin
    ccen_d = cc_q;
    crow_d = row_q - 16'd2;
    for (int k = 0; k < 2; k++) begin
      if (ccen_d == '0) begin
        ccen_d = CW'(width_i - WW'(1));
        crow_d = crow_d - 16'd1;
      end else begin
        ccen_d = ccen_d - CW'(1);
      end
    end
  end

  // Columns of the window that fall inside the map row
  always_comb begin
    logic [WW:0] ext, wext;
    ext  = (WW+1)'(ccen_q);
    wext = (WW+1)'(width_i);
    colok[0] = (ext + (WW+1)'(2)) < wext;
    colok[1] = (ext + (WW+1)'(1)) < wext;
    colok[2] = 1'b1;
    colok[3] = (ccen_q != '0);
    colok[4] = (ccen_q >= CW'(2));
  end

  // Scan one window row: max delta over 5 cells, sum over the inner 3 in rows 1 to 3
  always_comb begin
    logic [15:0]        rmax, cs;
    logic [19:0]        rsum;
    logic [3:0]         rcnt;
    logic signed [16:0] diff;
    logic [15:0]        dabs;
    hmtc_pkg::entry_t   e;
    logic               ok;
    rmax = maxd_q;
    rsum = sum_q;
    rcnt = cnt_q;
    cs   = win_q[2][2].sample;
    for (int c = 0; c < WS; c++) begin
      e    = win_q[sr_q][c];
      ok   = e.inmap && !e.uninit && colok[c];
      diff = signed'({cs[15], cs}) - signed'({e.sample[15], e.sample});
      dabs = diff[16] ? 16'(-diff) : diff[15:0];
      if (ok && dabs > rmax) rmax = dabs;
      if (ok && sr_q >= 3'd1 && sr_q <= 3'd3 && c >= 1 && c <= 3) begin
        rsum = rsum + 20'(dabs);
        rcnt = rcnt + 4'd1;
      end
    end
    scan_max = rmax;
    scan_sum = rsum;
    scan_cnt = rcnt;
  end

  // Decide the class of the centre cell
  always_comb begin
    logic [19:0]       flat_cnt;
    logic [17:0]       two_max, three_flat;
    hmtc_pkg::entry_t  centre;
    centre     = win_q[2][2];
    flat_cnt   = 20'(cfg_i.flat_height_mm) * 20'(cnt_q);
    two_max    = 18'({maxd_q, 1'b0});
    three_flat = 18'(cfg_i.flat_height_mm) + 18'({cfg_i.flat_height_mm, 1'b0});
    unique case (cfg_i.classify_mode)
      hmtc_pkg::MODE_ALL_FLAT:  cls = hmtc_pkg::CLS_FLAT;
      hmtc_pkg::MODE_MASK_ONLY: cls = centre.masked ? hmtc_pkg::CLS_WALL : hmtc_pkg::CLS_FLAT;
      default: begin
        if (centre.uninit) cls = hmtc_pkg::CLS_UNINIT;
        else if (maxd_q > cfg_i.min_wall_height_mm) cls = hmtc_pkg::CLS_WALL;
        else if (sum_q > flat_cnt || two_max > three_flat) cls = hmtc_pkg::CLS_OBSTACLE;
        else if (maxd_q <= cfg_i.flat_height_mm) cls = hmtc_pkg::CLS_FLAT;
        else cls = hmtc_pkg::CLS_OBSTACLE;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hmtc_pkg::ST_IDLE: begin
        if (q_valid_i && !restart_i) state_d = hmtc_pkg::ST_SHIFT;
      end
      hmtc_pkg::ST_SHIFT: begin
        if (emit && win_q[2][1].inmap) begin
          if (cfg_i.classify_mode == hmtc_pkg::MODE_ALL_FLAT ||
              cfg_i.classify_mode == hmtc_pkg::MODE_MASK_ONLY) begin
            state_d = hmtc_pkg::ST_DECIDE;
          end else begin
            state_d = hmtc_pkg::ST_SCAN;
          end
        end else begin
          state_d = hmtc_pkg::ST_IDLE;
        end
      end
      hmtc_pkg::ST_SCAN: begin
        if (sr_q == 3'(WS - 1)) state_d = hmtc_pkg::ST_DECIDE;
      end
      hmtc_pkg::ST_DECIDE: begin
        if (!out_valid_q || pop_i) state_d = hmtc_pkg::ST_IDLE;
      end
      default: state_d = hmtc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop_o  = 1'b0;
    mem_rd   = 1'b0;
    mem_wr   = 1'b0;
    do_shift = 1'b0;
    do_scan  = 1'b0;
    load     = 1'b0;
    unique case (state_q)
      hmtc_pkg::ST_IDLE: begin
        q_pop_o = q_valid_i && !restart_i;
        mem_rd  = q_valid_i && !restart_i;
      end
      hmtc_pkg::ST_SHIFT: begin
        mem_wr   = 1'b1;
        do_shift = 1'b1;
      end
      hmtc_pkg::ST_SCAN: do_scan = 1'b1;
      hmtc_pkg::ST_DECIDE: load = !out_valid_q || pop_i;
      default: ;
    endcase
  end

  // Latch the popped cell
  always_ff @(posedge clk_i) begin
    if (q_pop_o) ent_q <= q_entry_i;
  end

  // Advance the sequencer, stream position and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmtc_pkg::ST_IDLE;
      cc_q    <= '0;
      row_q   <= '0;
      seen_q  <= '0;
      sr_q    <= '0;
    end else if (restart_i) begin
      state_q <= hmtc_pkg::ST_IDLE;
      cc_q    <= '0;
      row_q   <= '0;
      seen_q  <= '0;
      sr_q    <= '0;
    end else begin
      state_q <= state_d;
      if (do_shift) begin
        if (WW'(cc_q) + WW'(1) >= width_i) begin
          cc_q  <= '0;
          row_q <= row_q + 16'd1;
        end else begin
          cc_q <= cc_q + CW'(1);
        end
        if (seen_q < wx[WS-1]) seen_q <= seen_q + SW'(1);
        sr_q <= '0;
      end else if (do_scan) begin
        sr_q <= sr_q + 3'd1;
      end
    end
  end

  // Shift the window one column; drop it all on restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < WS; r++) begin
        for (int c = 0; c < WS; c++) win_q[r][c] <= '0;
      end
    end else if (restart_i) begin
      for (int r = 0; r < WS; r++) begin
        for (int c = 0; c < WS; c++) win_q[r][c] <= '0;
      end
    end else if (do_shift) begin
      for (int r = 0; r < WS; r++) begin
        win_q[r][0] <= head[r];
        for (int c = 1; c < WS; c++) win_q[r][c] <= win_q[r][c-1];
      end
    end
  end

  // Hold centre position and scan accumulators
  always_ff @(posedge clk_i) begin
    if (do_shift) begin
      ccen_q <= ccen_d;
      crow_q <= crow_d;
      maxd_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else if (do_scan) begin
      maxd_q <= scan_max;
      sum_q  <= scan_sum;
      cnt_q  <= scan_cnt;
    end
  end

  // Result word register
  assign colx = 32'(ccen_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cls_q  <= cls;
      col_q  <= colx[9:0];
      orow_q <= crow_q;
    end
  end

  assign empty_o       = !out_valid_q;
  assign cell_class_o  = cls_q;
  assign cell_column_o = col_q;
  assign cell_row_o    = orow_q;

  `HMTC_ASSERT(a_seen_sat, seen_q <= wx[WS-1], "fill count beyond four rows")
  `HMTC_ASSERT(a_col_range, WW'(cc_q) < width_i, "column counter beyond row width")
  `HMTC_ASSERT(a_scan_centre, (state_q == hmtc_pkg::ST_SCAN) |-> win_q[2][2].inmap,
               "scanning a window whose centre is off the map")

endmodule

`default_nettype wire

>>> design/heightmap_terrain_classifier.sv
// Heightmap terrain classifier top level: configuration registers, front and back ends.
//
// Cells enter in raster order through a queue-style push port and come out classified
// (not initialised, flat, drivable obstacle or wall) with their column and row, lagging
// the input by 2*row_width+2 words; drain words push the last results out and give no
// result of their own. The back end pops and reads each word, then shifts it in; a word
// that gives a result is then scanned (full mode only) and decided; a shared unit scans
// the 5x5 window one row per cycle; four line buffers of MAX_WIDTH cells, read and then
// written once per word, feed the window. A two-word queue and a one-word result register
// let the input and output sides stall on their own. Line buffer contents are never
// cleared: a fill count marks which cells belong to the current stream, so no clearing
// pass runs after reset. Writing row_width restarts the stream.
`default_nettype none

module heightmap_terrain_classifier #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [15:0] height_mm_i,
  input  wire logic [15:0] sample_height_mm_i,
  input  wire logic [31:0] variance_i,
  input  wire logic        masked_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       cell_class_o,
  output logic [9:0]       cell_column_o,
  output logic [15:0]      cell_row_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [1:0]       classify_mode_q;
  logic [15:0]      min_wall_q;
  logic [15:0]      flat_q;
  logic [10:0]      row_width_q;
  logic             wr_en;
  logic [1:0]       reg_idx;
  logic             restart;
  logic [WW-1:0]    width_eff;
  hmtc_pkg::cfg_t   cfg;
  hmtc_pkg::entry_t q_entry;
  logic             q_valid, q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign restart = wr_en && (reg_idx == hmtc_pkg::REG_ROW_WIDTH);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      classify_mode_q <= hmtc_pkg::RST_CLASSIFY_MODE;
      min_wall_q      <= hmtc_pkg::RST_MIN_WALL;
      flat_q          <= hmtc_pkg::RST_FLAT;
      row_width_q     <= hmtc_pkg::RST_ROW_WIDTH;
    end else if (wr_en) begin
      unique case (reg_idx)
        hmtc_pkg::REG_CLASSIFY_MODE: classify_mode_q <= pwdata[1:0];
        hmtc_pkg::REG_MIN_WALL:      min_wall_q      <= pwdata[15:0];
        hmtc_pkg::REG_FLAT:          flat_q          <= pwdata[15:0];
        hmtc_pkg::REG_ROW_WIDTH:     row_width_q     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      hmtc_pkg::REG_CLASSIFY_MODE: prdata = 32'(classify_mode_q);
      hmtc_pkg::REG_MIN_WALL:      prdata = 32'(min_wall_q);
      hmtc_pkg::REG_FLAT:          prdata = 32'(flat_q);
      hmtc_pkg::REG_ROW_WIDTH:     prdata = 32'(row_width_q);
      default:                     prdata = '0;
    endcase
  end

  // Row width in use: zero acts as one, clamp to the line buffer length
  always_comb begin
    if (row_width_q == '0) width_eff = WW'(1);
    else if (32'(row_width_q) > MAX_WIDTH) width_eff = WW'(MAX_WIDTH);
    else width_eff = WW'(row_width_q);
  end

  assign cfg.classify_mode      = classify_mode_q;
  assign cfg.min_wall_height_mm = min_wall_q;
  assign cfg.flat_height_mm     = flat_q;

  hmtc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (push),
    .full_o             (full),
    .mode_i             (mode_i),
    .height_mm_i        (height_mm_i),
    .sample_height_mm_i (sample_height_mm_i),
    .variance_i         (variance_i),
    .masked_i           (masked_i),
    .q_valid_o          (q_valid),
    .q_entry_o          (q_entry),
    .q_pop_i            (q_pop)
  );

  hmtc_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .width_i       (width_eff),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .cell_class_o  (cell_class_o),
    .cell_column_o (cell_column_o),
    .cell_row_o    (cell_row_o)
  );

endmodule

`default_nettype wire
